@@ rtl/okt_pkg.sv @@
// Shared constants and types for the on-off keyed remote frame transmitter.
`timescale 1ns / 1ps

package okt_pkg;

  localparam int SENDER_BITS = 26;
  localparam int UNIT_BITS   = 4;
  localparam int DATA_BITS   = SENDER_BITS + 2 + UNIT_BITS;
  localparam int BIT_IDX_W   = $clog2(DATA_BITS);
  localparam int LAST_SEG    = 4 + 4 * DATA_BITS;
  localparam int SEG_W       = 8;
  localparam int TIME_W      = 14;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TIME_W-1:0] SHORT_RST = 14'd281;
  localparam logic [TIME_W-1:0] LONG_RST  = 14'd1346;
  localparam logic [TIME_W-1:0] SYNC_RST  = 14'd9900;
  localparam logic [TIME_W-1:0] START_RST = 14'd2772;

  localparam logic [CFG_IDX_W-1:0] REG_SHORT_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_GAP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_GAP   = 2'd3;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] short_pulse;
    logic [TIME_W-1:0] long_gap;
    logic [TIME_W-1:0] sync_gap;
    logic [TIME_W-1:0] start_gap;
  } okt_cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
  } okt_res_t;

endpackage

@@ rtl/okt_seq.sv @@
// Segment sequencer: frame word, segment index, gap timer and line level.
`timescale 1ns / 1ps

module okt_seq
  import okt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   operation_i,
  input  logic [SENDER_BITS-1:0] sender_code_i,
  input  logic [UNIT_BITS-1:0]   unit_code_i,
  input  logic                   switch_on_i,
  input  okt_cfg_t               cfg_i,
  output okt_res_t               res_o
);

  logic [DATA_BITS-1:0] frame_q, frame_d;
  logic [SEG_W-1:0]     seg_q, seg_d;
  logic [TIME_W-1:0]    time_q, time_d;
  logic                 level_q, level_d;
  logic                 sending_q, sending_d;
  logic                 done;

  logic [TIME_W-1:0]    time_dec;
  logic [SEG_W-1:0]     seg_inc;
  logic [SEG_W-1:0]     seg_ofs;
  logic [BIT_IDX_W-1:0] bit_pos;
  logic                 data_bit;
  logic                 nxt_level;
  logic [TIME_W-1:0]    nxt_len;
  logic [TIME_W-1:0]    short_len;
  logic [TIME_W-1:0]    long_len;

  function automatic logic [TIME_W-1:0] at_least_one(input logic [TIME_W-1:0] v);
    return (v == '0) ? TIME_W'(1) : v;
  endfunction

  assign time_dec  = time_q - TIME_W'(1);
  assign seg_inc   = seg_q + SEG_W'(1);
  assign seg_ofs   = seg_inc - SEG_W'(4);
  assign bit_pos   = BIT_IDX_W'(DATA_BITS - 1) - seg_ofs[BIT_IDX_W+1:2];
  assign data_bit  = frame_q[bit_pos];
  assign short_len = at_least_one(cfg_i.short_pulse);
  assign long_len  = at_least_one(cfg_i.long_gap);

  // Level and length of the segment that follows the current one.
  always_comb begin
    nxt_level = 1'b1;
    nxt_len   = short_len;
    if (seg_inc == SEG_W'(1)) begin
      nxt_level = 1'b0;
      nxt_len   = at_least_one(cfg_i.sync_gap);
    end else if (seg_inc == SEG_W'(3)) begin
      nxt_level = 1'b0;
      nxt_len   = at_least_one(cfg_i.start_gap);
    end else if (seg_inc > SEG_W'(3) && seg_inc < SEG_W'(LAST_SEG)) begin
      case (seg_ofs[1:0])
        2'd1: begin
          nxt_level = 1'b0;
          nxt_len   = data_bit ? long_len : short_len;
        end
        2'd3: begin
          nxt_level = 1'b0;
          nxt_len   = data_bit ? short_len : long_len;
        end
        default: begin
          nxt_level = 1'b1;
          nxt_len   = short_len;
        end
      endcase
    end
  end

  always_comb begin
    frame_d   = frame_q;
    seg_d     = seg_q;
    time_d    = time_q;
    level_d   = level_q;
    sending_d = sending_q;
    done      = 1'b0;
    if (step_i) begin
      if (operation_i == OP_START) begin
        if (!sending_q) begin
          frame_d   = {sender_code_i, 1'b0, switch_on_i, unit_code_i};
          seg_d     = '0;
          level_d   = 1'b1;
          time_d    = short_len;
          sending_d = 1'b1;
        end
      end else if (sending_q) begin
        time_d = time_dec;
        if (time_dec == '0) begin
          if (seg_inc <= SEG_W'(LAST_SEG)) begin
            seg_d   = seg_inc;
            level_d = nxt_level;
            time_d  = nxt_len;
          end else begin
            seg_d     = '0;
            level_d   = 1'b0;
            sending_d = 1'b0;
            done      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      seg_q     <= '0;
      time_q    <= '0;
      level_q   <= 1'b0;
      sending_q <= 1'b0;
    end else begin
      frame_q   <= frame_d;
      seg_q     <= seg_d;
      time_q    <= time_d;
      level_q   <= level_d;
      sending_q <= sending_d;
    end
  end

  assign res_o.line_level = level_d;
  assign res_o.busy       = sending_d;
  assign res_o.frame_done = done;

endmodule

@@ rtl/okt_out_buf.sv @@
// Output register with a skid stage for result words.
`timescale 1ns / 1ps

module okt_out_buf
  import okt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  okt_res_t data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output okt_res_t data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  okt_res_t out_data_q, out_data_d;
  okt_res_t skid_data_q, skid_data_d;
  logic     out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;

endmodule

@@ rtl/ook_remote_frame_transmitter.sv @@
// Top level of the on-off keyed remote-control frame transmitter.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_stall_o  operation, sender_code, unit_code, switch_on
//   result    out        out_valid_o/out_stall_i line_level, busy_res, frame_done
//   config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Words are handled combinationally; a new one can be taken every cycle while in_stall_o is low.
// Its result is registered, in the skid stage instead while the output stalls.
// A skid stage keeps taking words while one result waits; input stalls
// only when both result slots hold words. Reset clears the frame state and
// loads the default timing registers; the config port is always ready.
`timescale 1ns / 1ps

module ook_remote_frame_transmitter
  import okt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   operation_i,
  input  logic [SENDER_BITS-1:0] sender_code_i,
  input  logic [UNIT_BITS-1:0]   unit_code_i,
  input  logic                   switch_on_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   line_level_o,
  output logic                   busy_res_o,
  output logic                   frame_done_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [TIME_W-1:0]      cfg_data_i
);

  okt_cfg_t cfg_q, cfg_d;
  okt_res_t res_next;
  okt_res_t res_out;
  logic     buf_full;
  logic     in_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_take     = in_valid_i && !buf_full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SHORT_PULSE: cfg_d.short_pulse = cfg_data_i;
        REG_LONG_GAP:    cfg_d.long_gap    = cfg_data_i;
        REG_SYNC_GAP:    cfg_d.sync_gap    = cfg_data_i;
        REG_START_GAP:   cfg_d.start_gap   = cfg_data_i;
        default:         cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_pulse <= SHORT_RST;
      cfg_q.long_gap    <= LONG_RST;
      cfg_q.sync_gap    <= SYNC_RST;
      cfg_q.start_gap   <= START_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  okt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_take),
    .operation_i   (operation_i),
    .sender_code_i (sender_code_i),
    .unit_code_i   (unit_code_i),
    .switch_on_i   (switch_on_i),
    .cfg_i         (cfg_q),
    .res_o         (res_next)
  );

  okt_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_take),
    .data_i      (res_next),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out)
  );

  assign line_level_o = res_out.line_level;
  assign busy_res_o   = res_out.busy;
  assign frame_done_o = res_out.frame_done;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the on-off keyed remote frame transmitter.
`timescale 1ns / 1ps

module tb_top;
  import okt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 5;

  typedef struct packed {
    logic                   op;
    logic [SENDER_BITS-1:0] sender;
    logic [UNIT_BITS-1:0]   unit;
    logic                   sw_on;
    logic                   known;
    okt_res_t               res;
  } stim_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic                   operation_i   = OP_TICK;
  logic [SENDER_BITS-1:0] sender_code_i = '0;
  logic [UNIT_BITS-1:0]   unit_code_i   = '0;
  logic                   switch_on_i   = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic                   line_level_o;
  logic                   busy_res_o;
  logic                   frame_done_o;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = REG_SHORT_PULSE;
  logic [TIME_W-1:0]      cfg_data_i    = '0;

  // Timing registers and frame state as the transmitter should hold them.
  logic [TIME_W-1:0]    timing_reg [4] = '{SHORT_RST, LONG_RST, SYNC_RST, START_RST};
  logic [DATA_BITS-1:0] frame_word = '0;
  logic [SEG_W-1:0]     seg_now    = '0;
  logic [TIME_W-1:0]    dwell_left = '0;
  logic                 key_level  = 1'b0;
  logic                 in_frame   = 1'b0;

  okt_res_t    keying_due [$];
  stim_row_t   opening [6];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  int unsigned       phase_items [PHASES] = '{50, 200, 60, 60, 60};
  logic [TIME_W-1:0] phase_timing [PHASES][4] = '{
    '{14'd1, 14'd2, 14'd3, 14'd0},
    '{14'd1, 14'd1, 14'd1, 14'd1},
    '{14'd1, 14'd3, 14'd5, 14'd2},
    '{14'd1, 14'd2, 14'd60, 14'd1},
    '{14'd0, 14'd1, 14'd2, 14'd2}
  };

  ook_remote_frame_transmitter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .sender_code_i (sender_code_i),
    .unit_code_i   (unit_code_i),
    .switch_on_i   (switch_on_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .line_level_o  (line_level_o),
    .busy_res_o    (busy_res_o),
    .frame_done_o  (frame_done_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit segment_shape(input logic [SEG_W-1:0] s, output logic lvl,
                                       output logic [TIME_W-1:0] len);
    int   k;
    logic b;
    lvl = 1'b0;
    len = timing_reg[REG_SHORT_PULSE];
    if (s > LAST_SEG) return 1'b0;
    if (s == 0 || s == 2 || s == LAST_SEG) begin
      lvl = 1'b1;
    end else if (s == 1) begin
      len = timing_reg[REG_SYNC_GAP];
    end else if (s == 3) begin
      len = timing_reg[REG_START_GAP];
    end else begin
      k = s - 4;
      b = frame_word[DATA_BITS - 1 - k / 4];
      case (k % 4)
        0, 2: lvl = 1'b1;
        1: len = b ? timing_reg[REG_LONG_GAP] : timing_reg[REG_SHORT_PULSE];
        default: len = b ? timing_reg[REG_SHORT_PULSE] : timing_reg[REG_LONG_GAP];
      endcase
    end
    if (len == 0) len = TIME_W'(1);
    return 1'b1;
  endfunction

  function automatic okt_res_t step_frame(input stim_row_t w);
    okt_res_t          r;
    logic              lvl;
    logic [TIME_W-1:0] len;
    r.frame_done = 1'b0;
    if (w.op == OP_START) begin
      if (!in_frame) begin
        frame_word = {w.sender, 1'b0, w.sw_on, w.unit};
        seg_now = '0;
        void'(segment_shape(seg_now, lvl, len));
        key_level = lvl;
        dwell_left = len;
        in_frame = 1'b1;
      end
    end else if (in_frame) begin
      dwell_left = dwell_left - 1'b1;
      if (dwell_left == 0) begin
        seg_now = seg_now + 1'b1;
        if (segment_shape(seg_now, lvl, len)) begin
          key_level = lvl;
          dwell_left = len;
        end else begin
          in_frame = 1'b0;
          key_level = 1'b0;
          seg_now = '0;
          r.frame_done = 1'b1;
        end
      end
    end
    r.line_level = key_level;
    r.busy = in_frame;
    return r;
  endfunction

  // Mostly ticks inside a frame, mostly starts between frames.
  function automatic stim_row_t pick_word();
    stim_row_t w;
    if (in_frame) w.op = ($urandom_range(99) < 5) ? OP_START : OP_TICK;
    else w.op = ($urandom_range(99) < 75) ? OP_START : OP_TICK;
    w.sender = SENDER_BITS'($urandom());
    w.unit = UNIT_BITS'($urandom());
    w.sw_on = 1'($urandom());
    w.known = 1'b0;
    w.res = '0;
    return w;
  endfunction

  function automatic void flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic send_word(input stim_row_t w);
    okt_res_t model;
    int       gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 27) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= w.op;
    sender_code_i <= w.sender;
    unit_code_i <= w.unit;
    switch_on_i <= w.sw_on;
    do @(posedge clk_i); while (in_stall_o);
    model = step_frame(w);
    keying_due.push_back(w.known ? w.res : model);
  endtask

  task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    timing_reg[idx] = val;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    out_stall_i <= !calm && ($urandom_range(99) < 27);
  end

  always @(posedge clk_i) begin
    okt_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (keying_due.size() == 0) begin
        flag_error($sformatf("unexpected word level %b busy %b done %b",
                             line_level_o, busy_res_o, frame_done_o));
      end else begin
        want = keying_due.pop_front();
        if (line_level_o !== want.line_level)
          flag_error($sformatf("line level expected %b got %b", want.line_level, line_level_o));
        if (busy_res_o !== want.busy)
          flag_error($sformatf("busy expected %b got %b", want.busy, busy_res_o));
        if (frame_done_o !== want.frame_done)
          flag_error($sformatf("frame done expected %b got %b", want.frame_done, frame_done_o));
      end
    end
  end

  initial begin
    // Under reset timing: idle ticks, a start, an ignored start, then ticks.
    opening[0] = '{OP_TICK,  '1, '1, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0}};
    opening[1] = '{OP_TICK,  '0, '0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0}};
    opening[2] = '{OP_START, '0, '0, 1'b0, 1'b1, '{1'b1, 1'b1, 1'b0}};
    opening[3] = '{OP_START, '1, '1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0}};
    opening[4] = '{OP_TICK,  '1, '1, 1'b1, 1'b1, '{1'b1, 1'b1, 1'b0}};
    opening[5] = '{OP_TICK,  '0, '0, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0}};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) send_word(opening[i]);
    in_valid_i <= 1'b0;
    // The first timing change lands in the middle of the opening frame.
    for (int p = 0; p < PHASES; p++) begin
      while (keying_due.size() != 0) @(posedge clk_i);
      for (int r = 0; r < 4; r++) write_timing(CFG_IDX_W'(r), phase_timing[p][r]);
      cfg_valid_i <= 1'b0;
      calm = (p == 1);
      for (int n = 0; n < phase_items[p]; n++) send_word(pick_word());
      while (in_frame) send_word(pick_word());
      in_valid_i <= 1'b0;
    end
    calm = 1'b0;
    while (keying_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
